// ----- design/mpmf_pkg.sv -----
// Shared types and constants for the modular polynomial multiply/fold unit.
// No dependencies.
package mpmf_pkg;

   localparam int MAX_LEN_DEF = 32;
   localparam int COEF_BITS   = 32;
   localparam int ADDR_BITS   = 5;    // index into a coefficient store
   localparam int CNT_BITS    = 6;    // load counters and length registers
   localparam int FOLD_BITS   = 7;
   localparam int K_BITS      = 8;    // power of x while walking, may pass 64
   localparam int IDX_BITS    = 6;
   localparam int ACC_DEPTH   = 64;
   // exact signed sum of up to 1024 products of 32-bit values
   localparam int ACC_BITS    = 76;
   localparam int MAG_BITS    = ACC_BITS - 1;

   typedef enum logic [1:0] {
      CMD_LOAD_A  = 2'd0,
      CMD_LOAD_B  = 2'd1,
      CMD_COMPUTE = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      REG_MODULUS  = 2'd0,
      REG_LEN_A    = 2'd1,
      REG_LEN_B    = 2'd2,
      REG_FOLD_LEN = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SEEK,
      SEQ_MAC
   } seq_state_type;

   // one step from the sequencer: a multiply-accumulate or an end of slot
   typedef struct packed {
      logic                 valid;
      logic                 is_end;
      logic                 sign;
      logic                 last;
      logic [IDX_BITS-1:0]  idx;
      logic [ADDR_BITS-1:0] ia;
      logic [ADDR_BITS-1:0] jb;
   } op_type;

   // one stage of the reduction chain
   typedef struct packed {
      logic                 valid;
      logic                 neg;
      logic                 last;
      logic [IDX_BITS-1:0]  idx;
      logic [COEF_BITS-1:0] r;
      logic [MAG_BITS-1:0]  rest;
   } link_type;

endpackage

// ----- design/mpmf_cell.sv -----
// One reduction cell: takes one dividend bit, keeps the remainder below q.
// Depends on mpmf_pkg.
module mpmf_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [mpmf_pkg::COEF_BITS-1:0] q,
   input  mpmf_pkg::link_type            d_in,
   output mpmf_pkg::link_type            d_out
);

   mpmf_pkg::link_type          link_ff, link_in;
   logic [mpmf_pkg::COEF_BITS:0] t;

   always_comb begin
      t = {d_in.r, d_in.rest[mpmf_pkg::MAG_BITS-1]};
      link_in = d_in;
      link_in.rest = {d_in.rest[mpmf_pkg::MAG_BITS-2:0], 1'b0};
      if (t >= {1'b0, q}) begin
         link_in.r = mpmf_pkg::COEF_BITS'(t - {1'b0, q});
      end else begin
         link_in.r = mpmf_pkg::COEF_BITS'(t);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff.valid <= 1'b0;
      end else begin
         link_ff.valid <= link_in.valid;
      end
      link_ff.neg  <= link_in.neg;
      link_ff.last <= link_in.last;
      link_ff.idx  <= link_in.idx;
      link_ff.r    <= link_in.r;
      link_ff.rest <= link_in.rest;
   end

   assign d_out = link_ff;

endmodule

// ----- design/mpmf_seq.sv -----
// Sequencer: walks output slots, powers of x in each slot and coefficient pairs.
// Depends on mpmf_pkg.
module mpmf_seq (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           go,
   input  logic [mpmf_pkg::CNT_BITS-1:0]  na,
   input  logic [mpmf_pkg::CNT_BITS-1:0]  nb,
   input  logic [mpmf_pkg::FOLD_BITS-1:0] n,
   output mpmf_pkg::op_type               op
);

   mpmf_pkg::seq_state_type state_ff, state_in;
   logic [mpmf_pkg::IDX_BITS-1:0]  s_ff, s_in;
   logic [mpmf_pkg::K_BITS-1:0]    k_ff, k_in;
   logic [mpmf_pkg::ADDR_BITS-1:0] i_ff, i_in, ihi_ff, ihi_in;
   logic                           sign_ff, sign_in;

   logic [mpmf_pkg::K_BITS-1:0]    plen, nres, ilo, ihi, k_next, jb;
   logic                           k_past, empty, slot_last;

   always_comb begin
      plen = mpmf_pkg::K_BITS'(na) + mpmf_pkg::K_BITS'(nb);
      nres = (n == '0) ? plen : mpmf_pkg::K_BITS'(n);
      ilo = (k_ff >= mpmf_pkg::K_BITS'(nb)) ? k_ff - mpmf_pkg::K_BITS'(nb) + 8'd1 : '0;
      ihi = (k_ff < mpmf_pkg::K_BITS'(na)) ? k_ff : mpmf_pkg::K_BITS'(na) - 8'd1;
      k_past = (k_ff >= plen);
      empty = (ilo > ihi);
      slot_last = (mpmf_pkg::K_BITS'(s_ff) == nres - 8'd1);
      // full product: one power per slot; fold: next wrap of the same slot
      k_next = (n == '0) ? plen : k_ff + mpmf_pkg::K_BITS'(n);
      jb = k_ff - mpmf_pkg::K_BITS'(i_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mpmf_pkg::SEQ_IDLE: begin
            if (go) state_in = mpmf_pkg::SEQ_SEEK;
         end
         mpmf_pkg::SEQ_SEEK: begin
            if (k_past && slot_last) state_in = mpmf_pkg::SEQ_IDLE;
            else if (!k_past && !empty) state_in = mpmf_pkg::SEQ_MAC;
         end
         mpmf_pkg::SEQ_MAC: begin
            if (i_ff == ihi_ff) state_in = mpmf_pkg::SEQ_SEEK;
         end
         default: state_in = mpmf_pkg::SEQ_IDLE;
      endcase
   end

   // counters
   always_comb begin
      s_in = s_ff;
      k_in = k_ff;
      i_in = i_ff;
      ihi_in = ihi_ff;
      sign_in = sign_ff;
      unique case (state_ff)
         mpmf_pkg::SEQ_IDLE: begin
            s_in = '0;
            k_in = '0;
            sign_in = 1'b0;
         end
         mpmf_pkg::SEQ_SEEK: begin
            if (k_past) begin
               s_in = s_ff + 6'd1;
               k_in = mpmf_pkg::K_BITS'(s_ff) + 8'd1;
               sign_in = 1'b0;
            end else if (empty) begin
               k_in = k_next;
               sign_in = ~sign_ff;
            end else begin
               i_in = ilo[mpmf_pkg::ADDR_BITS-1:0];
               ihi_in = ihi[mpmf_pkg::ADDR_BITS-1:0];
            end
         end
         mpmf_pkg::SEQ_MAC: begin
            if (i_ff == ihi_ff) begin
               k_in = k_next;
               sign_in = ~sign_ff;
            end else begin
               i_in = i_ff + 5'd1;
            end
         end
         default: ;
      endcase
   end

   // outputs
   always_comb begin
      op = '0;
      op.idx = s_ff;
      op.sign = sign_ff;
      op.ia = i_ff;
      op.jb = jb[mpmf_pkg::ADDR_BITS-1:0];
      unique case (state_ff)
         mpmf_pkg::SEQ_SEEK: begin
            if (k_past) begin
               op.valid = 1'b1;
               op.is_end = 1'b1;
               op.last = slot_last;
            end
         end
         mpmf_pkg::SEQ_MAC: op.valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mpmf_pkg::SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
      s_ff <= s_in;
      k_ff <= k_in;
      i_ff <= i_in;
      ihi_ff <= ihi_in;
      sign_ff <= sign_in;
   end

endmodule

// ----- design/modular_polynomial_multiply_fold_unit.sv -----
// Top level: coefficient stores, multiply-accumulate pipeline, reduction chain.
// Depends on mpmf_pkg, mpmf_seq and mpmf_cell.
//
// Loads (cmd 0, 1) do not raise busy and can follow each other back to back.
// A compute holds busy from its request until the last result. It runs through the
// single multiply-accumulate pipeline (one coefficient pair per cycle) and the
// 75-cell modular reduction chain. Results come out on rsp_strobe for one
// cycle each, in rising index order; the receiver cannot stall them.
module modular_polynomial_multiply_fold_unit #(
   parameter int MAX_LEN = mpmf_pkg::MAX_LEN_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_cmd,
   input  logic [mpmf_pkg::COEF_BITS-1:0]  req_coef,
   output logic                            rsp_strobe,
   output logic [mpmf_pkg::COEF_BITS-1:0]  rsp_result_coef,
   output logic [mpmf_pkg::IDX_BITS-1:0]   rsp_result_index,
   output logic                            rsp_last,
   input  logic                            csr_we,
   input  logic [1:0]                      csr_index,
   input  logic [mpmf_pkg::COEF_BITS-1:0]  csr_wdata
);

   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   logic [mpmf_pkg::COEF_BITS-1:0] modulus_ff;
   logic [mpmf_pkg::CNT_BITS-1:0]  len_a_ff, len_b_ff, count_a_ff, count_b_ff;
   logic [mpmf_pkg::FOLD_BITS-1:0] fold_len_ff;
   logic                           busy_ff, busy_in;

   logic [mpmf_pkg::COEF_BITS-1:0] store_a [MAX_LEN];
   logic [mpmf_pkg::COEF_BITS-1:0] store_b [MAX_LEN];

   logic accept, go, load_a, load_b;
   logic [mpmf_pkg::CNT_BITS-1:0]  na, nb;
   logic [mpmf_pkg::FOLD_BITS-1:0] n;
   mpmf_pkg::op_type op0, op1_ff, op2_ff;
   logic av1_ff, bv1_ff;
   logic [mpmf_pkg::COEF_BITS-1:0]   a_rd_ff, b_rd_ff;
   logic [2*mpmf_pkg::COEF_BITS-1:0] prod_ff;
   logic signed [mpmf_pkg::ACC_BITS-1:0] acc_ff, acc_in, prod_ext, acc_neg;
   mpmf_pkg::link_type link [mpmf_pkg::MAG_BITS+1];
   mpmf_pkg::link_type tail;
   logic [mpmf_pkg::COEF_BITS-1:0] res;

   logic                           strobe_ff, last_ff;
   logic [mpmf_pkg::COEF_BITS-1:0] coef_ff;
   logic [mpmf_pkg::IDX_BITS-1:0]  index_ff;

   assign accept = start && !busy_ff;
   assign go = accept && (req_cmd == mpmf_pkg::CMD_COMPUTE);
   assign load_a = accept && (req_cmd == mpmf_pkg::CMD_LOAD_A)
                   && (count_a_ff < mpmf_pkg::CNT_BITS'(MAX_LEN));
   assign load_b = accept && (req_cmd == mpmf_pkg::CMD_LOAD_B)
                   && (count_b_ff < mpmf_pkg::CNT_BITS'(MAX_LEN));

   always_comb begin
      if (len_a_ff == '0) na = 6'd1;
      else if (len_a_ff > mpmf_pkg::CNT_BITS'(MAX_LEN)) na = mpmf_pkg::CNT_BITS'(MAX_LEN);
      else na = len_a_ff;
      if (len_b_ff == '0) nb = 6'd1;
      else if (len_b_ff > mpmf_pkg::CNT_BITS'(MAX_LEN)) nb = mpmf_pkg::CNT_BITS'(MAX_LEN);
      else nb = len_b_ff;
      n = (fold_len_ff > mpmf_pkg::FOLD_BITS'(mpmf_pkg::ACC_DEPTH))
          ? mpmf_pkg::FOLD_BITS'(mpmf_pkg::ACC_DEPTH) : fold_len_ff;
   end

   always_comb begin
      busy_in = busy_ff;
      if (go) busy_in = 1'b1;
      else if (strobe_ff && last_ff) busy_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff  <= 32'd65537;
         len_a_ff    <= 6'd32;
         len_b_ff    <= 6'd32;
         fold_len_ff <= '0;
         count_a_ff  <= '0;
         count_b_ff  <= '0;
         busy_ff     <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         if (csr_we) begin
            unique case (mpmf_pkg::reg_index_type'(csr_index))
               mpmf_pkg::REG_MODULUS:  modulus_ff  <= csr_wdata;
               mpmf_pkg::REG_LEN_A:    len_a_ff    <= csr_wdata[mpmf_pkg::CNT_BITS-1:0];
               mpmf_pkg::REG_LEN_B:    len_b_ff    <= csr_wdata[mpmf_pkg::CNT_BITS-1:0];
               mpmf_pkg::REG_FOLD_LEN: fold_len_ff <= csr_wdata[mpmf_pkg::FOLD_BITS-1:0];
               default: ;
            endcase
         end
         if (strobe_ff && last_ff) begin
            count_a_ff <= '0;
            count_b_ff <= '0;
         end else begin
            if (load_a) count_a_ff <= count_a_ff + 6'd1;
            if (load_b) count_b_ff <= count_b_ff + 6'd1;
         end
      end
   end

   // coefficient stores
   always_ff @(posedge clock) begin
      if (load_a) store_a[count_a_ff[AW-1:0]] <= req_coef;
      if (load_b) store_b[count_b_ff[AW-1:0]] <= req_coef;
      a_rd_ff <= store_a[op0.ia[AW-1:0]];
      b_rd_ff <= store_b[op0.jb[AW-1:0]];
   end

   mpmf_seq u_seq (
      .clock (clock),
      .reset (reset),
      .go    (go),
      .na    (na),
      .nb    (nb),
      .n     (n),
      .op    (op0)
   );

   // positions past the load count read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         op1_ff.valid <= 1'b0;
         op2_ff.valid <= 1'b0;
      end else begin
         op1_ff.valid <= op0.valid;
         op2_ff.valid <= op1_ff.valid;
      end
      op1_ff.is_end <= op0.is_end;
      op1_ff.sign   <= op0.sign;
      op1_ff.last   <= op0.last;
      op1_ff.idx    <= op0.idx;
      op1_ff.ia     <= op0.ia;
      op1_ff.jb     <= op0.jb;
      av1_ff <= (mpmf_pkg::CNT_BITS'(op0.ia) < count_a_ff);
      bv1_ff <= (mpmf_pkg::CNT_BITS'(op0.jb) < count_b_ff);
      op2_ff.is_end <= op1_ff.is_end;
      op2_ff.sign   <= op1_ff.sign;
      op2_ff.last   <= op1_ff.last;
      op2_ff.idx    <= op1_ff.idx;
      op2_ff.ia     <= op1_ff.ia;
      op2_ff.jb     <= op1_ff.jb;
      prod_ff <= (av1_ff ? a_rd_ff : '0) * (bv1_ff ? b_rd_ff : '0);
   end

   // exact signed accumulation per slot; reduced once at slot end
   always_comb begin
      prod_ext = mpmf_pkg::ACC_BITS'(prod_ff);
      acc_in = acc_ff;
      if (op2_ff.valid) begin
         if (op2_ff.is_end) acc_in = '0;
         else if (op2_ff.sign) acc_in = acc_ff - prod_ext;
         else acc_in = acc_ff + prod_ext;
      end
      acc_neg = -acc_ff;
      link[0].valid = op2_ff.valid && op2_ff.is_end;
      link[0].neg   = acc_ff[mpmf_pkg::ACC_BITS-1];
      link[0].last  = op2_ff.last;
      link[0].idx   = op2_ff.idx;
      link[0].r     = '0;
      link[0].rest  = acc_ff[mpmf_pkg::ACC_BITS-1] ? acc_neg[mpmf_pkg::MAG_BITS-1:0]
                                                   : acc_ff[mpmf_pkg::MAG_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   for (genvar c = 0; c < mpmf_pkg::MAG_BITS; c++) begin : g_chain
      mpmf_cell u_cell (
         .clock (clock),
         .reset (reset),
         .q     (modulus_ff),
         .d_in  (link[c]),
         .d_out (link[c+1])
      );
   end

   always_comb begin
      tail = link[mpmf_pkg::MAG_BITS];
      if (modulus_ff < 32'd2) res = '0;
      else if (tail.neg && (tail.r != '0)) res = modulus_ff - tail.r;
      else res = tail.r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= tail.valid;
      end
      last_ff  <= tail.last;
      coef_ff  <= res;
      index_ff <= tail.idx;
   end

   assign busy             = busy_ff;
   assign rsp_strobe       = strobe_ff;
   assign rsp_result_coef  = coef_ff;
   assign rsp_result_index = index_ff;
   assign rsp_last         = strobe_ff && last_ff;

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> busy_ff)
      else $error("result outside a compute");
   a_go_busy: assert property (@(posedge clock) disable iff (reset)
      go |=> busy_ff)
      else $error("compute did not raise busy");
   a_count_a: assert property (@(posedge clock) disable iff (reset)
      count_a_ff <= mpmf_pkg::CNT_BITS'(MAX_LEN))
      else $error("load count A overflow");
   a_acc_clear: assert property (@(posedge clock) disable iff (reset)
      (op2_ff.valid && op2_ff.is_end) |=> (acc_ff == '0))
      else $error("accumulator not cleared after slot end");

endmodule
